// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL modules (clk and rst_n taken from the module).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bbmm_pkg.sv =====
// Types and constants shared by the button-byte to mouse-motion block.
package bbmm_pkg;

    // Field widths
    localparam int STEP_W    = 21;
    localparam int MOVE_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Speed limit and diagonal scale (46341/65536 ~ 1/sqrt(2))
    localparam longint STEP_CAP = 1048576;
    localparam logic [15:0] DIAG_MUL = 16'd46341;
    localparam int DIAG_SHIFT = 16;
    localparam logic [STEP_W-1:0] SPEED_STEP_RESET = 21'd65536;

    // Bit positions in a received byte
    localparam int DIR_UP     = 0;
    localparam int DIR_DOWN   = 1;
    localparam int DIR_LEFT   = 2;
    localparam int DIR_RIGHT  = 3;
    localparam int BYTE_LBTN  = 4;
    localparam int BYTE_RBTN  = 5;
    localparam int BYTE_FRAME = 7;

    // Register index (paddr[2])
    localparam logic REG_SPEED_STEP = 1'b0;

    // Result queue
    localparam int FIFO_DEPTH  = 8;
    localparam int PTR_W       = 3;
    localparam int CNT_W       = 4;
    localparam int READY_LIMIT = FIFO_DEPTH - 2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic {
        KIND_BUTTON = 1'b0,
        KIND_MOVE   = 1'b1
    } kind_t;

    typedef enum logic {
        BTN_LEFT  = 1'b0,
        BTN_RIGHT = 1'b1
    } btn_t;

    typedef struct packed {
        kind_t                     kind;
        btn_t                      which_button;
        logic                      pressed;
        logic signed [MOVE_W-1:0]  move_x;
        logic signed [MOVE_W-1:0]  move_y;
        logic                      last;
    } result_t;

    // Results produced by one item: num of them, first then second
    typedef struct packed {
        logic [1:0] num;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// ===== rtl/core/button_byte_to_mouse_motion_unit.sv =====
// Top level of the button-byte to mouse-motion block.
//
// Input stream (s_*): s_tuser is the op (0 = serial byte, 1 = timer tick),
// s_tdata carries the byte. A byte with bit 7 set is a frame: bits 0..3 are
// up/down/left/right, bits 4/5 the left/right buttons. Other bytes are dropped.
// Output stream (m_*): one beat per event. m_tuser = kind (0 button, 1 move),
// m_tlast marks the final event caused by one input beat.
// Config: APB, speed_step at byte address 0 (travel per tick, 1/2^FRAC_BITS px).
// Flow: an accepted beat is held in the input register and its events are
// written from there to an 8-entry result queue, whose head drives m_tvalid.
// Throughput: one input beat per cycle while the queue has room; a frame can
// yield two events, and the queue drains one event per cycle while m_tready
// is high, which sets the sustained rate for frames that change both buttons.
// s_tready drops when the queue plus in-flight results could exceed its depth;
// a stalled receiver fills the queue and then holds the input side. Reset
// empties the queue, clears direction, buttons and accumulators, and sets
// speed_step to 65536.
module button_byte_to_mouse_motion_unit
    import bbmm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    input  logic              s_tuser,   // [0] op
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [0] which_button, [1] pressed,
                                         // [7:2] move_x, [13:8] move_y, [15:14] zero
    output logic              m_tuser,   // [0] kind
    output logic              m_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [STEP_W-1:0] speed_step;
    logic              pending;
    logic              in_take;
    push_t             push;
    result_t           head;
    logic [CNT_W-1:0]  count;

    bbmm_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .speed_step (speed_step)
    );

    // Room for the in-flight item and the new one, two results each
    assign s_tready = ((CNT_W+1)'(count) + (pending ? (CNT_W+1)'(2) : '0))
                      <= (CNT_W+1)'(READY_LIMIT);
    assign in_take  = s_tvalid && s_tready;

    bbmm_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .in_op      (op_t'(s_tuser)),
        .in_byte    (s_tdata),
        .speed_step (speed_step),
        .pending    (pending),
        .push       (push)
    );

    bbmm_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_tready),
        .head_valid (m_tvalid),
        .head       (head),
        .count      (count)
    );

    // Output beat packing
    assign m_tdata = {2'b00, head.move_y, head.move_x, head.pressed, head.which_button};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

// ===== rtl/core/bbmm_regs.sv =====
// APB register file holding speed_step.
module bbmm_regs
    import bbmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [STEP_W-1:0] speed_step
);

    logic              hit;
    logic [STEP_W-1:0] speed_step_reg;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == REG_SPEED_STEP);

    // Write on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_step_reg <= SPEED_STEP_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            speed_step_reg <= pwdata[STEP_W-1:0];
        end
    end

    // Readback
    assign prdata     = hit ? APB_DW'(speed_step_reg) : '0;
    assign speed_step = speed_step_reg;

endmodule

// ===== rtl/core/bbmm_core.sv =====
// Input register, frame/tick update logic and button/direction/accumulator state.
`include "assert_macros.svh"

module bbmm_core
    import bbmm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  op_t               in_op,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic [STEP_W-1:0] speed_step,
    output logic              pending,
    output push_t             push
);

    localparam int ACC_W = FRAC_BITS + 8;
    localparam longint CAP_WIDE = longint'(16) << FRAC_BITS;
    localparam longint CAP_LIM  = (CAP_WIDE > STEP_CAP) ? STEP_CAP : CAP_WIDE;
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(CAP_LIM);
    localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << FRAC_BITS) - ACC_W'(1);
    localparam int PROD_W = STEP_W + DIAG_SHIFT;

    // Whole part of an accumulator, truncated toward zero
    function automatic logic signed [MOVE_W-1:0] whole_of(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0]  mag;
        logic [MOVE_W-1:0] w;
        mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        w   = MOVE_W'(mag >> FRAC_BITS);
        whole_of = s[ACC_W-1] ? $signed(-w) : $signed(w);
    endfunction

    // Fraction left after the whole part is removed; keeps the sign
    function automatic logic signed [ACC_W-1:0] frac_of(input logic signed [ACC_W-1:0] s);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] rem;
        mag = s[ACC_W-1] ? ACC_W'(-s) : ACC_W'(s);
        rem = mag & FRAC_MASK;
        frac_of = s[ACC_W-1] ? $signed(-rem) : $signed(rem);
    endfunction

    // Input register
    logic              pend_reg;
    op_t               op_reg;
    logic [BYTE_W-1:0] byte_reg;

    // Block state
    logic [3:0]              dir_reg,   dir_next;
    logic                    left_reg,  left_next;
    logic                    right_reg, right_next;
    logic signed [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic signed [ACC_W-1:0] acc_y_reg, acc_y_next;

    // Tick datapath
    logic [STEP_W-1:0]       step;
    logic [PROD_W-1:0]       diag_prod;
    logic [STEP_W-1:0]       vmag;
    logic signed [ACC_W-1:0] vmag_a;
    logic                    x_nz, y_nz;
    logic signed [ACC_W-1:0] vx, vy, sum_x, sum_y;
    logic signed [MOVE_W-1:0] dx, dy;
    logic                    lc, rc, l_chg, r_chg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= in_op;
            byte_reg <= in_byte;
        end
    end

    assign pending = pend_reg;

    // Velocity: saturated step, scaled on diagonals
    assign step      = (speed_step > STEP_MAX) ? STEP_MAX : speed_step;
    assign diag_prod = PROD_W'(step) * PROD_W'(DIAG_MUL);
    assign x_nz      = dir_reg[DIR_LEFT] ^ dir_reg[DIR_RIGHT];
    assign y_nz      = dir_reg[DIR_UP] ^ dir_reg[DIR_DOWN];
    assign vmag      = (x_nz && y_nz) ? diag_prod[PROD_W-1:DIAG_SHIFT] : step;
    assign vmag_a    = $signed(ACC_W'(vmag));
    assign vx        = !x_nz ? '0 : (dir_reg[DIR_RIGHT] ? vmag_a : -vmag_a);
    assign vy        = !y_nz ? '0 : (dir_reg[DIR_DOWN] ? vmag_a : -vmag_a);

    // Accumulate and split off whole pixels
    assign sum_x = acc_x_reg + vx;
    assign sum_y = acc_y_reg + vy;
    assign dx    = whole_of(sum_x);
    assign dy    = whole_of(sum_y);

    // Button edges
    assign lc    = byte_reg[BYTE_LBTN];
    assign rc    = byte_reg[BYTE_RBTN];
    assign l_chg = (lc != left_reg);
    assign r_chg = (rc != right_reg);

    // Next state and results
    always_comb
    begin
        dir_next   = dir_reg;
        left_next  = left_reg;
        right_next = right_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        push       = '0;
        if (pend_reg)
        begin
            case (op_reg)
                OP_BYTE:
                begin
                    if (byte_reg[BYTE_FRAME])
                    begin
                        dir_next   = byte_reg[3:0];
                        left_next  = lc;
                        right_next = rc;
                        if (l_chg)
                        begin
                            push.first.kind         = KIND_BUTTON;
                            push.first.which_button = BTN_LEFT;
                            push.first.pressed      = lc;
                            push.first.last         = !r_chg;
                            if (r_chg)
                            begin
                                push.num                 = 2'd2;
                                push.second.kind         = KIND_BUTTON;
                                push.second.which_button = BTN_RIGHT;
                                push.second.pressed      = rc;
                                push.second.last         = 1'b1;
                            end
                            else
                            begin
                                push.num = 2'd1;
                            end
                        end
                        else if (r_chg)
                        begin
                            push.num                = 2'd1;
                            push.first.kind         = KIND_BUTTON;
                            push.first.which_button = BTN_RIGHT;
                            push.first.pressed      = rc;
                            push.first.last         = 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    // an axis whose velocity came out zero (also after scaling) is cleared
                    acc_x_next = (vx != '0) ? frac_of(sum_x) : '0;
                    acc_y_next = (vy != '0) ? frac_of(sum_y) : '0;
                    if (dx != '0 || dy != '0)
                    begin
                        push.num          = 2'd1;
                        push.first.kind   = KIND_MOVE;
                        push.first.move_x = dx;
                        push.first.move_y = dy;
                        push.first.last   = 1'b1;
                    end
                end
                default:
                begin
                    push = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            left_reg  <= 1'b0;
            right_reg <= 1'b0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else
        begin
            dir_reg   <= dir_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            acc_x_reg <= acc_x_next;
            acc_y_reg <= acc_y_next;
        end
    end

    `ASSERT_IMPLY(a_non_frame_silent, pend_reg && op_reg == OP_BYTE && !byte_reg[BYTE_FRAME], push.num == 2'd0, "non-frame byte produced a result")
    `ASSERT_IMPLY(a_pair_order, push.num == 2'd2, push.first.which_button == BTN_LEFT && push.second.which_button == BTN_RIGHT && !push.first.last && push.second.last, "button pair out of order")
    `ASSERT_IMPLY(a_move_range, push.num != 2'd0 && push.first.kind == KIND_MOVE, push.first.move_x >= -6'sd16 && push.first.move_x <= 6'sd16 && push.first.move_y >= -6'sd16 && push.first.move_y <= 6'sd16, "move out of range")
    `ASSERT_NEXT(a_idle_axis_clear, pend_reg && op_reg == OP_TICK && !x_nz, acc_x_reg == '0, "idle x accumulator not cleared")

endmodule

// ===== rtl/core/bbmm_out_fifo.sv =====
// Result queue: takes up to two results a cycle, hands out one.
`include "assert_macros.svh"

module bbmm_out_fifo
    import bbmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  push_t            push,
    input  logic             pop,
    output logic             head_valid,
    output result_t          head,
    output logic [CNT_W-1:0] count
);

    result_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign do_pop     = pop && head_valid;
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign count      = count_reg;

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push.num);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(do_pop);
            count_reg  <= count_reg + CNT_W'(push.num) - CNT_W'(do_pop);
        end
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(FIFO_DEPTH), "queue count past depth")
    `ASSERT_ALWAYS(a_no_overflow, (32'(count_reg) + 32'(push.num)) <= FIFO_DEPTH, "queue overflow")
    `ASSERT_NEXT(a_pop_drains, do_pop && push.num == 2'd0, count_reg == $past(count_reg) - CNT_W'(1), "pop did not drain")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the button-byte to mouse-motion block.
`timescale 1ns / 1ps

module testbench;
    import bbmm_pkg::*;

    localparam int FRAC = 16;
    localparam logic [APB_AW-1:0] SPEED_STEP_ADDR = {REG_SPEED_STEP, 2'b00};

    // One input beat, or a marker that holds the sender until all events are in
    typedef struct {
        op_t        op;
        logic [7:0] rx;
        bit         pause;
    } mouse_item_t;

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;    // [7:0] rx_byte
    logic              s_tuser = 1'b0;  // [0] op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;         // [0] which_button, [1] pressed,
                                        // [7:2] move_x, [13:8] move_y, [15:14] zero
    logic              m_tuser;         // [0] kind
    logic              m_tlast;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Mirror of the block's state and register
    logic [STEP_W-1:0] speed_step = SPEED_STEP_RESET;
    logic [3:0]        dir_bits   = '0;
    logic              left_held  = 1'b0;
    logic              right_held = 1'b0;
    longint            accum_x    = 0;
    longint            accum_y    = 0;

    mouse_item_t pending_items[$];
    result_t     expected_events[$];
    logic        beat_taken  = 1'b0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          errors      = 0;

    button_byte_to_mouse_motion_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Works out the events one accepted beat causes and queues them
    function automatic void predict_mouse_events(op_t op, logic [7:0] rx);
        result_t ev [2];
        int      n;
        longint  cap, step, vx, vy, dx, dy;
        n = 0;
        ev[0] = '0;
        ev[1] = '0;
        if (op == OP_BYTE) begin
            // bytes without the frame bit are dropped
            if (!rx[BYTE_FRAME])
                return;
            dir_bits = rx[3:0];
            if (rx[BYTE_LBTN] != left_held)
            begin
                ev[n].kind         = KIND_BUTTON;
                ev[n].which_button = BTN_LEFT;
                ev[n].pressed      = rx[BYTE_LBTN];
                n++;
            end
            if (rx[BYTE_RBTN] != right_held)
            begin
                ev[n].kind         = KIND_BUTTON;
                ev[n].which_button = BTN_RIGHT;
                ev[n].pressed      = rx[BYTE_RBTN];
                n++;
            end
            left_held  = rx[BYTE_LBTN];
            right_held = rx[BYTE_RBTN];
        end else begin
            // saturate the step, then build the velocity per axis
            cap = longint'(16) << FRAC;
            if (cap > STEP_CAP)
                cap = STEP_CAP;
            step = longint'(speed_step);
            if (step > cap)
                step = cap;
            vx = 0;
            vy = 0;
            if (dir_bits[DIR_LEFT])  vx -= step;
            if (dir_bits[DIR_RIGHT]) vx += step;
            if (dir_bits[DIR_UP])    vy -= step;
            if (dir_bits[DIR_DOWN])  vy += step;
            // diagonal: scale magnitudes, truncating
            if (vx != 0 && vy != 0)
            begin
                vx = (vx < 0) ? -(((-vx) * longint'(DIAG_MUL)) >>> DIAG_SHIFT)
                              : ((vx * longint'(DIAG_MUL)) >>> DIAG_SHIFT);
                vy = (vy < 0) ? -(((-vy) * longint'(DIAG_MUL)) >>> DIAG_SHIFT)
                              : ((vy * longint'(DIAG_MUL)) >>> DIAG_SHIFT);
            end
            accum_x += vx;
            accum_y += vy;
            // whole pixels, truncated toward zero
            dx = (accum_x >= 0) ? (accum_x >>> FRAC) : -((-accum_x) >>> FRAC);
            dy = (accum_y >= 0) ? (accum_y >>> FRAC) : -((-accum_y) >>> FRAC);
            accum_x -= dx * (longint'(1) << FRAC);
            accum_y -= dy * (longint'(1) << FRAC);
            if (dx != 0 || dy != 0)
            begin
                ev[n].kind   = KIND_MOVE;
                ev[n].move_x = dx[MOVE_W-1:0];
                ev[n].move_y = dy[MOVE_W-1:0];
                n++;
            end
            if (vx == 0)
                accum_x = 0;
            if (vy == 0)
                accum_y = 0;
        end
        if (n > 0)
            ev[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_events.push_back(ev[i]);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Sender: next beat from the pending queue, with random gaps
    always @(negedge clk)
    begin : beat_driver
        logic        drive;
        mouse_item_t item;
        if (rst_n && (!s_tvalid || beat_taken))
        begin
            drive = 1'b0;
            if (pending_items.size() > 0 && pending_items[0].pause)
            begin
                if (expected_events.size() == 0)
                    void'(pending_items.pop_front());
            end else if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                item    = pending_items.pop_front();
                drive   = 1'b1;
                s_tdata <= item.rx;
                s_tuser <= item.op;
            end
            s_tvalid <= drive;
        end
    end

    // Receiver stalls
    always @(negedge clk)
    begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Predict on accepted input beats, check output beats in order
    always @(posedge clk)
    begin : event_monitor
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_mouse_events(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event: kind %0d tdata %h last %0d",
                           m_tuser, m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("which_button", want.which_button, m_tdata[0]);
                    check_field("pressed", want.pressed, m_tdata[1]);
                    check_field("move_x", want.move_x, $signed(m_tdata[7:2]));
                    check_field("move_y", want.move_y, $signed(m_tdata[13:8]));
                    check_field("tdata_pad", 0, m_tdata[15:14]);
                    check_field("last", want.last, m_tlast);
                end
            end
        end
        beat_taken <= rst_n && s_tvalid && s_tready;
    end

    task automatic add_item(op_t op, logic [7:0] rx);
        mouse_item_t item;
        item.op    = op;
        item.rx    = rx;
        item.pause = 1'b0;
        pending_items.push_back(item);
    endtask

    // Mostly a frame followed by a run of ticks; some noise bytes and lone ticks
    task automatic add_random_items(int count);
        mouse_item_t hold;
        int          added, pause_at, ticks;
        added    = 0;
        pause_at = $urandom_range(count - 1);
        hold.op    = OP_TICK;
        hold.rx    = '0;
        hold.pause = 1'b1;
        while (added < count)
        begin
            if (added >= pause_at && pause_at >= 0)
            begin
                pending_items.push_back(hold);
                pause_at = -1;
            end
            case ($urandom_range(9))
                0:       add_item(OP_BYTE, {1'b0, 7'($urandom)});
                1:
                begin
                    add_item(OP_TICK, 8'($urandom));
                    added++;
                end
                default:
                begin
                    add_item(OP_BYTE, {1'b1, 7'($urandom)});
                    added++;
                    ticks = $urandom_range(6);
                    for (int i = 0; i < ticks; i++)
                        add_item(OP_TICK, 8'($urandom));
                    added += ticks;
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_events.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write of speed_step, then read it back
    task automatic set_speed_step(logic [STEP_W-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = SPEED_STEP_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel       = 1'b0;
        penable    = 1'b0;
        speed_step = value;
        @(negedge clk);
        psel   = 1'b1;
        pwrite = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        check_field("speed_step", APB_DW'(value), prdata);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial
    begin : stimulus
        logic [STEP_W-1:0] steps [8];
        steps[0] = '0;
        steps[1] = 21'(STEP_CAP);
        steps[2] = '1;
        steps[3] = 21'($urandom_range(1048575, 1));
        steps[4] = 21'd1;
        steps[5] = 21'(STEP_CAP - 1);
        steps[6] = 21'($urandom_range(131072, 32768));
        steps[7] = SPEED_STEP_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset step
        tx_idle_pct = 36;
        rx_idle_pct = 61;
        add_item(OP_TICK, 8'h00);   // no direction: no move
        add_item(OP_BYTE, 8'h7F);   // non-frame byte, ignored
        add_item(OP_BYTE, 8'h00);
        add_item(OP_BYTE, 8'h80);   // empty frame
        add_item(OP_BYTE, 8'hB0);   // both buttons down: two events
        add_item(OP_BYTE, 8'h90);   // right up
        add_item(OP_BYTE, 8'h80);   // left up
        add_item(OP_BYTE, 8'hA0);   // right down
        add_item(OP_BYTE, 8'h81);   // right up, moving up
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h82);   // down
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h84);   // left
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h88);   // right
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h89);   // diagonal: scaled, builds up
        add_item(OP_TICK, 8'h00);
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h83);   // opposing vertical bits cancel
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'h8C);   // opposing horizontal bits cancel
        add_item(OP_TICK, 8'h00);
        add_item(OP_BYTE, 8'hFF);   // all bits set, both buttons down
        add_item(OP_TICK, 8'hFF);   // tick ignores its byte
        wait_drained();

        // Random phases, one step setting each
        for (int p = 0; p < 8; p++)
        begin
            set_speed_step(steps[p]);
            tx_idle_pct = (p < 3) ? 36 : (p < 6) ? 61 : 0;
            rx_idle_pct = (p < 3) ? 61 : (p < 6) ? 36 : 0;
            add_random_items(250);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
